@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file macd_chk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge, reset included
`define ASSERT_SYNC(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

// property checked only while reset is low
`define ASSERT_SYNC_RST(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

@@ rtl/macd_pkg.sv @@
`timescale 1ns / 1ps
package macd_pkg;

  localparam int DEF_PRICE_BITS = 32;
  // extra accumulator bits above the price width
  localparam int ACC_HEADROOM   = 16;
  localparam int PERIOD_BITS    = 6;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_FAST_PERIOD   = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_SLOW_PERIOD   = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_SIGNAL_PERIOD = CFG_IDX_BITS'(2);

  localparam logic [PERIOD_BITS-1:0] FAST_PERIOD_RST   = PERIOD_BITS'(12);
  localparam logic [PERIOD_BITS-1:0] SLOW_PERIOD_RST   = PERIOD_BITS'(26);
  localparam logic [PERIOD_BITS-1:0] SIGNAL_PERIOD_RST = PERIOD_BITS'(9);

  // a period of zero behaves as one
  function automatic logic [PERIOD_BITS-1:0] eff_period(input logic [PERIOD_BITS-1:0] r);
    return (r == '0) ? PERIOD_BITS'(1) : r;
  endfunction

endpackage

@@ rtl/macd_in_if.sv @@
`timescale 1ns / 1ps
interface macd_in_if import macd_pkg::*; #(
  parameter int PRICE_BITS = DEF_PRICE_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] close_price;

  modport source (output valid, output close_price, input ready);
  modport sink (input valid, input close_price, output ready);
endinterface

@@ rtl/macd_out_if.sv @@
`timescale 1ns / 1ps
interface macd_out_if import macd_pkg::*; #(
  parameter int PRICE_BITS = DEF_PRICE_BITS
) ();
  logic                       valid;
  logic                       ready;
  logic signed [PRICE_BITS:0]   macd_value;
  logic signed [PRICE_BITS:0]   signal_value;
  logic signed [PRICE_BITS+1:0] histogram_value;
  logic                       ready_res;

  modport source (output valid, output macd_value, output signal_value,
                  output histogram_value, output ready_res, input ready);
  modport sink (input valid, input macd_value, input signal_value,
                input histogram_value, input ready_res, output ready);
endinterface

@@ rtl/macd_indicator.sv @@
`timescale 1ns / 1ps
// channel      dir  payload                                          request
// price_in     in   close_price                                      one bar
// result_out   out  macd_value signal_value histogram_value ready_res one result per bar
// cfg_*        in   cfg_index cfg_data (write only)                  period update
//
// a bar is taken only in idle; it then runs up to three feeds (fast, slow, signal)
// each feed needing a rounded division runs ST_PREP, ST_DIV and ST_APPLY on the shared
// bit-serial divider; seeding bars without a division are shorter (ST_FEED to ST_STEP)
// the result sits in an output register, so the next bar is taken while it waits
// synchronous active-high reset clears state and all averages and loads the default periods
module macd_indicator import macd_pkg::*; #(
  parameter int PRICE_BITS = DEF_PRICE_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  macd_in_if.sink                 price_in,
  macd_out_if.source              result_out,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [PERIOD_BITS-1:0]  cfg_data
);

  localparam int ACC_BITS  = PRICE_BITS + ACC_HEADROOM;  // stored averages
  localparam int WORK_BITS = ACC_BITS + 2;               // sums and numerators
  localparam int DIV_BITS  = PERIOD_BITS + 1;            // divisor up to period+1
  localparam int CNT_BITS  = $clog2(WORK_BITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_FEED, ST_PREP, ST_DIV, ST_APPLY, ST_STEP, ST_OUT
  } state_t;

  // which average is being fed
  typedef enum logic [1:0] {
    SEL_FAST, SEL_SLOW, SEL_SIG
  } sel_t;

  state_t state;
  sel_t   sel;

  // configuration
  logic [PERIOD_BITS-1:0] fast_period;
  logic [PERIOD_BITS-1:0] slow_period;
  logic [PERIOD_BITS-1:0] signal_period;

  // averages hold the running sum while seeding
  logic signed [ACC_BITS-1:0] fast_avg;
  logic signed [ACC_BITS-1:0] slow_avg;
  logic signed [ACC_BITS-1:0] sig_avg;
  logic [PERIOD_BITS-1:0]     fast_cnt;
  logic [PERIOD_BITS-1:0]     slow_cnt;
  logic [PERIOD_BITS-1:0]     sig_cnt;

  // per-bar working registers
  logic [PRICE_BITS-1:0]      price;
  logic signed [ACC_BITS:0]   macd;
  logic                       sig_ready;
  logic signed [WORK_BITS-1:0] num;
  logic [DIV_BITS-1:0]        divisor;
  logic                       seed_mode;

  // shared divider: dq shifts the magnitude out and the quotient in
  logic [WORK_BITS-1:0] dq;
  logic [DIV_BITS-1:0]  rem;
  logic [CNT_BITS-1:0]  div_cnt;

  // output register
  logic                        out_valid;
  logic signed [PRICE_BITS:0]   out_macd;
  logic signed [PRICE_BITS:0]   out_sig;
  logic signed [PRICE_BITS+1:0] out_hist;
  logic                        out_rdy;

  // current operand selection
  logic [PERIOD_BITS-1:0]      cur_per;
  logic signed [ACC_BITS-1:0]  cur_avg;
  logic [PERIOD_BITS-1:0]      cur_cnt;
  logic signed [WORK_BITS-1:0] avg_ext;
  logic signed [WORK_BITS-1:0] x_ext;

  logic                        seeding;
  logic [PERIOD_BITS-1:0]      cnt_inc;
  logic                        seed_done;
  logic signed [WORK_BITS-1:0] seed_sum;
  logic signed [WORK_BITS-1:0] ema_diff;
  logic signed [WORK_BITS-1:0] ema_num;

  logic [WORK_BITS-1:0] half_ext;
  logic [WORK_BITS-1:0] mag_init;
  logic [DIV_BITS:0]    div_try;
  logic [DIV_BITS:0]    div_sub;
  logic                 div_ge;
  logic [DIV_BITS-1:0]  rem_next;

  logic signed [WORK_BITS-1:0] apply_base;
  logic signed [WORK_BITS-1:0] apply_val;

  logic                        avg_we;
  logic signed [ACC_BITS-1:0]  avg_wd;
  logic                        cnt_we;

  logic                        fast_seeded;
  logic                        slow_seeded;
  logic                        sig_seeded;
  logic signed [ACC_BITS+1:0]  hist_full;

  assign price_in.ready = (state == ST_IDLE);

  assign result_out.valid           = out_valid;
  assign result_out.macd_value      = out_macd;
  assign result_out.signal_value    = out_sig;
  assign result_out.histogram_value = out_hist;
  assign result_out.ready_res       = out_rdy;

  always_comb begin
    unique case (sel)
      SEL_FAST: begin
        cur_per = eff_period(fast_period);
        cur_avg = fast_avg;
        cur_cnt = fast_cnt;
      end
      SEL_SLOW: begin
        cur_per = eff_period(slow_period);
        cur_avg = slow_avg;
        cur_cnt = slow_cnt;
      end
      default: begin
        cur_per = eff_period(signal_period);
        cur_avg = sig_avg;
        cur_cnt = sig_cnt;
      end
    endcase
  end

  assign avg_ext = {{2{cur_avg[ACC_BITS-1]}}, cur_avg};
  // price feeds the fast and slow averages, the macd line feeds the signal one
  assign x_ext = (sel == SEL_SIG) ? {macd[ACC_BITS], macd}
                                  : {{(WORK_BITS-PRICE_BITS){1'b0}}, price};

  // feed step: either add into the seed sum or form 2*(x - avg)
  assign seeding   = cur_cnt < cur_per;
  assign cnt_inc   = cur_cnt + PERIOD_BITS'(1);
  assign seed_done = cnt_inc == cur_per;
  assign seed_sum  = avg_ext + x_ext;
  assign ema_diff  = x_ext - avg_ext;
  assign ema_num   = ema_diff <<< 1;

  // |num| + d/2 in one adder: for negative num use ~num plus one as carry
  assign half_ext = {{(WORK_BITS-DIV_BITS){1'b0}}, divisor >> 1};
  assign mag_init = (num[WORK_BITS-1] ? ~num : num) + half_ext
                    + {{(WORK_BITS-1){1'b0}}, num[WORK_BITS-1]};

  // restoring division, one quotient bit a cycle
  assign div_try  = {rem, dq[WORK_BITS-1]};
  assign div_ge   = div_try >= {1'b0, divisor};
  assign div_sub  = div_try - {1'b0, divisor};
  assign rem_next = div_ge ? div_sub[DIV_BITS-1:0] : div_try[DIV_BITS-1:0];

  // seed end replaces the sum, an update adds the signed quotient
  assign apply_base = seed_mode ? '0 : avg_ext;
  assign apply_val  = num[WORK_BITS-1] ? apply_base - signed'(dq) : apply_base + signed'(dq);

  always_comb begin
    avg_we = 1'b0;
    avg_wd = seed_sum[ACC_BITS-1:0];
    cnt_we = 1'b0;
    if (state == ST_FEED && seeding) begin
      cnt_we = 1'b1;
      avg_we = !seed_done;
    end
    if (state == ST_APPLY) begin
      avg_we = 1'b1;
      avg_wd = apply_val[ACC_BITS-1:0];
    end
  end

  assign fast_seeded = fast_cnt >= eff_period(fast_period);
  assign slow_seeded = slow_cnt >= eff_period(slow_period);
  assign sig_seeded  = sig_cnt >= eff_period(signal_period);

  assign hist_full = {macd[ACC_BITS], macd} - {{2{sig_avg[ACC_BITS-1]}}, sig_avg};

  // configuration and average storage
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_period   <= FAST_PERIOD_RST;
      slow_period   <= SLOW_PERIOD_RST;
      signal_period <= SIGNAL_PERIOD_RST;
      fast_avg      <= '0;
      slow_avg      <= '0;
      sig_avg       <= '0;
      fast_cnt      <= '0;
      slow_cnt      <= '0;
      sig_cnt       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FAST_PERIOD:   fast_period   <= cfg_data;
          REG_SLOW_PERIOD:   slow_period   <= cfg_data;
          REG_SIGNAL_PERIOD: signal_period <= cfg_data;
          default: ;  // no register there
        endcase
      end
      if (avg_we) begin
        unique case (sel)
          SEL_FAST: fast_avg <= avg_wd;
          SEL_SLOW: slow_avg <= avg_wd;
          default:  sig_avg  <= avg_wd;
        endcase
      end
      if (cnt_we) begin
        unique case (sel)
          SEL_FAST: fast_cnt <= cnt_inc;
          SEL_SLOW: slow_cnt <= cnt_inc;
          default:  sig_cnt  <= cnt_inc;
        endcase
      end
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sel       <= SEL_FAST;
      out_valid <= 1'b0;
    end else begin
      // the output step reloads the register itself
      if (result_out.ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (price_in.valid) begin
            price <= price_in.close_price;
            sel   <= SEL_FAST;
            state <= ST_FEED;
          end
        end
        ST_FEED: begin
          if (seeding) begin
            if (seed_done) begin
              // last seed value: divide the sum by the period
              num       <= seed_sum;
              divisor   <= {1'b0, cur_per};
              seed_mode <= 1'b1;
              state     <= ST_PREP;
            end else begin
              state <= ST_STEP;
            end
          end else begin
            num       <= ema_num;
            divisor   <= {1'b0, cur_per} + DIV_BITS'(1);
            seed_mode <= 1'b0;
            state     <= ST_PREP;
          end
        end
        ST_PREP: begin
          dq      <= mag_init;
          rem     <= '0;
          div_cnt <= CNT_BITS'(WORK_BITS);
          state   <= ST_DIV;
        end
        ST_DIV: begin
          dq      <= {dq[WORK_BITS-2:0], div_ge};
          rem     <= rem_next;
          div_cnt <= div_cnt - CNT_BITS'(1);
          if (div_cnt == CNT_BITS'(1)) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          state <= ST_STEP;
        end
        ST_STEP: begin
          unique case (sel)
            SEL_FAST: begin
              sel   <= SEL_SLOW;
              state <= ST_FEED;
            end
            SEL_SLOW: begin
              if (fast_seeded && slow_seeded) begin
                // macd from averages that already took this close
                macd  <= {fast_avg[ACC_BITS-1], fast_avg} - {slow_avg[ACC_BITS-1], slow_avg};
                sel   <= SEL_SIG;
                state <= ST_FEED;
              end else begin
                macd      <= '0;
                sig_ready <= 1'b0;
                state     <= ST_OUT;
              end
            end
            default: begin
              sig_ready <= sig_seeded;
              state     <= ST_OUT;
            end
          endcase
        end
        ST_OUT: begin
          if (!out_valid || result_out.ready) begin
            out_valid <= 1'b1;
            out_macd  <= macd[PRICE_BITS:0];
            out_sig   <= sig_ready ? sig_avg[PRICE_BITS:0] : '0;
            out_hist  <= sig_ready ? hist_full[PRICE_BITS+1:0] : '0;
            out_rdy   <= sig_ready;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/macd_chk.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module macd_chk import macd_pkg::*; #(
  parameter int PRICE_BITS = DEF_PRICE_BITS
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [PRICE_BITS:0]    signal_value,
  input logic [PRICE_BITS+1:0]  histogram_value,
  input logic                   ready_res
);

  // nothing pending right after reset
  `ASSERT_SYNC(a_rst_empty, clk, rst |=> !out_valid, "result pending after reset")

  // a result is not withdrawn while stalled
  `ASSERT_SYNC_RST(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped")

  // one bar at a time: busy right after taking a close
  `ASSERT_SYNC_RST(a_busy_after_take, clk, rst, in_valid && in_ready |=> !in_ready, "took two bars")

  // signal and histogram stay zero until the signal average is seeded
  `ASSERT_SYNC_RST(a_unseeded_zero, clk, rst, out_valid && !ready_res |-> signal_value == '0 && histogram_value == '0, "unseeded result not zero")

endmodule

bind macd_indicator macd_chk #(.PRICE_BITS(PRICE_BITS)) u_macd_chk (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (price_in.valid),
  .in_ready        (price_in.ready),
  .out_valid       (result_out.valid),
  .out_ready       (result_out.ready),
  .signal_value    (result_out.signal_value),
  .histogram_value (result_out.histogram_value),
  .ready_res       (result_out.ready_res)
);
